// ===== rtl/core/s2rgb_pkg.sv =====
// s2rgb_pkg: shared constants and codes of the scalar-to-RGB colormap.
// No dependencies; used by scalar_to_rgb_colormap and its testbench.
package s2rgb_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned ColorBitsDef  = 8;

  // hue wheel geometry
  localparam int unsigned HueDeg    = 360;
  localparam int unsigned SectorDeg = 60;
  localparam int unsigned HueBits   = 9;
  localparam int unsigned RemBits   = 6;

  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgMode      = 2'd0,
    CfgLowLimit  = 2'd1,
    CfgHighLimit = 2'd2,
    CfgCenter    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

endpackage

// ===== rtl/core/s2rgb_div.sv =====
// s2rgb_div: pipelined restoring divider, one quotient bit per register stage.
// Stage loads are driven by the caller's flow control. No package dependency.
module s2rgb_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 16,
  parameter int unsigned Q_W   = 9
) (
  input  logic             clk_i,
  input  logic [Q_W-1:0]   en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             rem_nz_o
);

  logic [DEN_W-1:0] par_q [Q_W];
  logic [Q_W-1:0]   low_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DEN_W-1:0] par_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (i == 0) begin : g_first
      // numerator is below den << Q_W, so its top part fits the remainder
      assign par_in = DEN_W'(num_i[NUM_W-1:Q_W]);
      assign low_in = num_i[Q_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign par_in = par_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign trial = {par_in, low_in[Q_W-1]};
    assign diff  = trial - {1'b0, den_i};
    assign take  = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        par_q[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[i] <= {low_in[Q_W-2:0], 1'b0};
        quo_q[i] <= {quo_in[Q_W-2:0], take};
      end
    end
  end

  assign quo_o    = quo_q[Q_W-1];
  assign rem_nz_o = |par_q[Q_W-1];

endmodule

// ===== rtl/core/scalar_to_rgb_colormap.sv =====
// scalar_to_rgb_colormap: false-color mapper, signed sample in, RGB out (jet or hue wheel).
// Depends on s2rgb_pkg and s2rgb_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / sample_value_i) takes one sample per
//   transfer. Output channel (out_valid_o / out_ready_i / red_o, green_o, blue_o)
//   delivers one pixel per sample, in order.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) writes
//   mode, low_limit, high_limit, center_point (index 0..3); always ready. Write it
//   only while no sample is in flight.
//   Pipeline: input, clamp, offset, numerators, divider stages, jet/hue, output register;
//   QB, the larger of COLOR_BITS and 9, is the quotient width. Throughput: one sample
//   per cycle while out_ready_i is high. The three dividers retire one quotient bit per
//   stage, which sets the pipeline depth; every stage holds its own valid bit.
//   Stall: when out_ready_i is low, stages fill up behind the output register and
//   in_ready_o drops only once every stage is occupied; bubbles are squeezed out.
//   Reset: clears all valid bits and loads mode = jet, low = 0, high = max positive,
//   center = quarter scale.
module scalar_to_rgb_colormap #(
  parameter int unsigned SAMPLE_BITS = s2rgb_pkg::SampleBitsDef,
  parameter int unsigned COLOR_BITS  = s2rgb_pkg::ColorBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [COLOR_BITS-1:0]               red_o,
  output logic [COLOR_BITS-1:0]               green_o,
  output logic [COLOR_BITS-1:0]               blue_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [s2rgb_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]              cfg_data_i
);

  localparam int unsigned S        = SAMPLE_BITS;
  localparam int unsigned C        = COLOR_BITS;
  localparam int unsigned HB       = s2rgb_pkg::HueBits;
  localparam int unsigned RB       = s2rgb_pkg::RemBits;
  localparam int unsigned QB       = (C > HB) ? C : HB;
  localparam int unsigned DivFirst = 4;
  localparam int unsigned Post1    = DivFirst + QB;
  localparam int unsigned NS       = Post1 + 2;
  localparam int unsigned NumR     = S + C;
  localparam int unsigned NumH     = S + HB;
  localparam int unsigned Full     = (1 << C) - 1;
  localparam logic [C-1:0] FullC   = '1;

  // configuration
  logic                cfg_we;
  logic                mode_q;
  logic signed [S-1:0] low_q, high_q, ctr_q;
  logic [S:0]          span_q, span_d, gspan_q, gspan_d;
  logic                span_zero, span_neg, gspan_zero, gspan_neg;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign span_d      = {high_q[S-1], high_q} - {low_q[S-1], low_q};
  assign gspan_d     = {high_q[S-1], high_q} - {ctr_q[S-1], ctr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      low_q   <= '0;
      high_q  <= {1'b0, {(S-1){1'b1}}};
      ctr_q   <= {2'b01, {(S-2){1'b0}}};
      span_q  <= {2'b00, {(S-1){1'b1}}};
      gspan_q <= {3'b000, {(S-2){1'b1}}};
    end else begin
      span_q  <= span_d;
      gspan_q <= gspan_d;
      if (cfg_we) begin
        case (s2rgb_pkg::cfg_reg_e'(cfg_index_i))
          s2rgb_pkg::CfgMode:      mode_q <= cfg_data_i[0];
          s2rgb_pkg::CfgLowLimit:  low_q  <= cfg_data_i;
          s2rgb_pkg::CfgHighLimit: high_q <= cfg_data_i;
          s2rgb_pkg::CfgCenter:    ctr_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign span_zero  = (span_q == '0);
  assign span_neg   = span_q[S];
  assign gspan_zero = (gspan_q == '0);
  assign gspan_neg  = gspan_q[S];

  // flow control: a stage loads when it is empty or its successor moves
  logic [NS-1:0] vld_q, vld_d, rdy, prev_vld, next_rdy;

  assign prev_vld = {vld_q[NS-2:0], in_valid_i};
  assign next_rdy = {out_ready_i, rdy[NS-1:1]};
  assign rdy      = ~vld_q | next_rdy;
  assign vld_d    = (rdy & prev_vld) | (~rdy & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // stage 0: input register
  logic signed [S-1:0] smp_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      smp_q <= sample_value_i;
    end
  end

  // stage 1: clamp, upper bound wins
  logic signed [S-1:0] v_d, v_q;

  always_comb begin
    v_d = smp_q;
    if (smp_q < low_q) begin
      v_d = low_q;
    end
    if (v_d > high_q) begin
      v_d = high_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      v_q <= v_d;
    end
  end

  // stage 2: offset from low and distance from center
  logic [S-1:0] a_d, a_q, dist_d, dist_q;
  logic [S:0]   dd, negd;

  assign a_d    = v_q - low_q;
  assign dd     = {v_q[S-1], v_q} - {ctr_q[S-1], ctr_q};
  assign negd   = ~dd + (S+1)'(1);
  assign dist_d = dd[S] ? negd[S-1:0] : dd[S-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      a_q    <= a_d;
      dist_q <= dist_d;
    end
  end

  // stage 3: scaled numerators
  logic [NumR-1:0] nr_q, ng_q;
  logic [NumH-1:0] nh_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      nr_q <= {a_q, {C{1'b0}}} - NumR'(a_q);
      nh_q <= NumH'(a_q) * NumH'(s2rgb_pkg::HueDeg);
      ng_q <= {dist_q, {C{1'b0}}} - NumR'(dist_q);
    end
  end

  // dividers, stages DivFirst .. Post1-1
  logic [QB-1:0] quo_r, quo_h, quo_g;
  logic          rnz_r;
  logic          gov_q [QB];

  s2rgb_div #(.NUM_W(NumR), .DEN_W(S), .Q_W(QB)) u_div_red (
    .clk_i    (clk_i),
    .en_i     (rdy[DivFirst +: QB]),
    .num_i    (nr_q),
    .den_i    (span_q[S-1:0]),
    .quo_o    (quo_r),
    .rem_nz_o (rnz_r)
  );

  s2rgb_div #(.NUM_W(NumH), .DEN_W(S), .Q_W(QB)) u_div_hue (
    .clk_i    (clk_i),
    .en_i     (rdy[DivFirst +: QB]),
    .num_i    (nh_q),
    .den_i    (span_q[S-1:0]),
    .quo_o    (quo_h),
    .rem_nz_o ()
  );

  s2rgb_div #(.NUM_W(NumR), .DEN_W(S), .Q_W(QB)) u_div_grn (
    .clk_i    (clk_i),
    .en_i     (rdy[DivFirst +: QB]),
    .num_i    (ng_q),
    .den_i    (gspan_q[S-1:0]),
    .quo_o    (quo_g),
    .rem_nz_o ()
  );

  // green quotient above full scale, carried alongside the divider
  for (genvar i = 0; i < QB; i++) begin : g_gov
    logic gov_in;
    if (i == 0) begin : g_first
      assign gov_in = (ng_q >= {gspan_q[S-1:0], {C{1'b0}}});
    end else begin : g_next
      assign gov_in = gov_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (rdy[DivFirst+i]) begin
        gov_q[i] <= gov_in;
      end
    end
  end

  // post stage 1: jet channels, hue sector and remainder
  logic [C-1:0]        qr, jr_d, jg_d, jb_d, jr_q, jg_q, jb_q;
  logic [HB-1:0]       hue, hue_off;
  s2rgb_pkg::sector_e  sec_d, sec_q;
  logic [RB-1:0]       rem_q;

  assign qr  = quo_r[C-1:0];
  assign hue = quo_h[HB-1:0];

  always_comb begin
    if (span_zero) begin
      jr_d = '0;
      jb_d = '0;
    end else if (span_neg) begin
      jr_d = FullC;
      jb_d = '0;
    end else begin
      jr_d = qr;
      jb_d = FullC - qr - {{(C-1){1'b0}}, rnz_r};
    end

    if (gspan_zero) begin
      jg_d = '0;
    end else if (gspan_neg) begin
      jg_d = FullC;
    end else if (gov_q[QB-1]) begin
      jg_d = '0;
    end else begin
      jg_d = FullC - quo_g[C-1:0];
    end

    hue_off = hue;
    if (hue >= HB'(s2rgb_pkg::HueDeg)) begin
      sec_d   = s2rgb_pkg::SecRed;
      hue_off = '0;
    end else if (hue >= HB'(5 * s2rgb_pkg::SectorDeg)) begin
      sec_d   = s2rgb_pkg::SecMagenta;
      hue_off = hue - HB'(5 * s2rgb_pkg::SectorDeg);
    end else if (hue >= HB'(4 * s2rgb_pkg::SectorDeg)) begin
      sec_d   = s2rgb_pkg::SecBlue;
      hue_off = hue - HB'(4 * s2rgb_pkg::SectorDeg);
    end else if (hue >= HB'(3 * s2rgb_pkg::SectorDeg)) begin
      sec_d   = s2rgb_pkg::SecCyan;
      hue_off = hue - HB'(3 * s2rgb_pkg::SectorDeg);
    end else if (hue >= HB'(2 * s2rgb_pkg::SectorDeg)) begin
      sec_d   = s2rgb_pkg::SecGreen;
      hue_off = hue - HB'(2 * s2rgb_pkg::SectorDeg);
    end else if (hue >= HB'(s2rgb_pkg::SectorDeg)) begin
      sec_d   = s2rgb_pkg::SecYellow;
      hue_off = hue - HB'(s2rgb_pkg::SectorDeg);
    end else begin
      sec_d   = s2rgb_pkg::SecRed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Post1]) begin
      jr_q  <= jr_d;
      jg_q  <= jg_d;
      jb_q  <= jb_d;
      sec_q <= sec_d;
      rem_q <= hue_off[RB-1:0];
    end
  end

  // ramp tables over one sector
  logic [C-1:0] inc_tab [s2rgb_pkg::SectorDeg];
  logic [C-1:0] dec_tab [s2rgb_pkg::SectorDeg];

  for (genvar r = 0; r < s2rgb_pkg::SectorDeg; r++) begin : g_ramp
    localparam int unsigned IncV = (Full * r) / s2rgb_pkg::SectorDeg;
    localparam int unsigned DecV = (Full * (s2rgb_pkg::SectorDeg - r)) / s2rgb_pkg::SectorDeg;
    assign inc_tab[r] = C'(IncV);
    assign dec_tab[r] = C'(DecV);
  end

  // post stage 2: output register
  logic [C-1:0] inc, dec, red_d, grn_d, blu_d, red_q, grn_q, blu_q;

  assign inc = inc_tab[rem_q];
  assign dec = dec_tab[rem_q];

  always_comb begin
    red_d = '0;
    grn_d = '0;
    blu_d = '0;
    if (!mode_q) begin
      red_d = jr_q;
      grn_d = jg_q;
      blu_d = jb_q;
    end else if (span_zero) begin
      red_d = '0;
    end else if (span_neg) begin
      red_d = FullC;
    end else begin
      case (sec_q)
        s2rgb_pkg::SecRed: begin
          red_d = FullC;
          grn_d = inc;
        end
        s2rgb_pkg::SecYellow: begin
          red_d = dec;
          grn_d = FullC;
        end
        s2rgb_pkg::SecGreen: begin
          grn_d = FullC;
          blu_d = inc;
        end
        s2rgb_pkg::SecCyan: begin
          grn_d = dec;
          blu_d = FullC;
        end
        s2rgb_pkg::SecBlue: begin
          red_d = inc;
          blu_d = FullC;
        end
        default: begin
          red_d = FullC;
          blu_d = dec;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      red_q <= red_d;
      grn_q <= grn_d;
      blu_q <= blu_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = grn_q;
  assign blue_o  = blu_q;

endmodule

// ===== sim/scalar_to_rgb_colormap_tb.sv =====
// Testbench for scalar_to_rgb_colormap: random and directed samples under jet and hue modes,
// with a predicting scoreboard that checks every pixel in order.
// Depends on s2rgb_pkg and the RTL top level only.
`timescale 1ns / 1ps

module scalar_to_rgb_colormap_tb;

  localparam int SampleBits    = s2rgb_pkg::SampleBitsDef;
  localparam int ColorBits     = s2rgb_pkg::ColorBitsDef;
  localparam longint FullScale = (longint'(1) << ColorBits) - 1;
  localparam int LatencyCycles = 14;
  localparam int MaxPrinted    = 40;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [ColorBits-1:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } pixel_t;

  class pixel_scoreboard;
    bit       hue_mode;
    longint   lo_lim;
    longint   hi_lim;
    longint   ctr;
    pixel_t   pixel_q[$];
    int       fails;

    function new();
      hue_mode = 1'b0;
      lo_lim   = 0;
      hi_lim   = (longint'(1) << (SampleBits - 1)) - 1;
      ctr      = longint'(1) << (SampleBits - 2);
      fails    = 0;
    endfunction

    function void write_reg(s2rgb_pkg::cfg_reg_e idx, logic [SampleBits-1:0] data);
      case (idx)
        s2rgb_pkg::CfgMode:      hue_mode = data[0];
        s2rgb_pkg::CfgLowLimit:  lo_lim   = longint'(signed'(data));
        s2rgb_pkg::CfgHighLimit: hi_lim   = longint'(signed'(data));
        s2rgb_pkg::CfgCenter:    ctr      = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
      return q;
    endfunction

    function longint clip(longint x);
      if (x < 0) return 0;
      if (x > FullScale) return FullScale;
      return x;
    endfunction

    function pixel_t map_sample(sample_t s);
      longint v, span, gspan, gap, hue, rem, inc, dec;
      longint r, g, b;
      v = longint'(s);
      if (v < lo_lim) v = lo_lim;
      if (v > hi_lim) v = hi_lim;
      span = hi_lim - lo_lim;
      r = 0;
      g = 0;
      b = 0;
      if (!hue_mode) begin
        gspan = hi_lim - ctr;
        gap   = (v < ctr) ? ctr - v : v - ctr;
        if (span != 0) begin
          r = clip(floor_quot(FullScale * (v - lo_lim), span));
          b = clip(floor_quot(FullScale * (hi_lim - v), span));
        end
        if (gspan != 0) g = clip(FullScale - floor_quot(FullScale * gap, gspan));
      end else if (span != 0) begin
        hue = floor_quot(longint'(s2rgb_pkg::HueDeg) * (v - lo_lim), span);
        if (hue < 0) hue = 0;
        if (hue > s2rgb_pkg::HueDeg) hue = s2rgb_pkg::HueDeg;
        rem = hue % s2rgb_pkg::SectorDeg;
        inc = floor_quot(FullScale * rem, s2rgb_pkg::SectorDeg);
        dec = floor_quot(FullScale * (s2rgb_pkg::SectorDeg - rem), s2rgb_pkg::SectorDeg);
        case ((hue / s2rgb_pkg::SectorDeg) % 6)
          s2rgb_pkg::SecRed:     begin r = FullScale; g = inc; end
          s2rgb_pkg::SecYellow:  begin r = dec; g = FullScale; end
          s2rgb_pkg::SecGreen:   begin g = FullScale; b = inc; end
          s2rgb_pkg::SecCyan:    begin g = dec; b = FullScale; end
          s2rgb_pkg::SecBlue:    begin r = inc; b = FullScale; end
          default:               begin r = FullScale; b = dec; end
        endcase
      end
      return '{r: chan_t'(r), g: chan_t'(g), b: chan_t'(b)};
    endfunction

    function void note_sample(sample_t s);
      pixel_q.push_back(map_sample(s));
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    task report(string msg);
      fails++;
      if (fails <= MaxPrinted) $display("tb: mismatch: %s", msg);
    endtask

    task check_pixel(chan_t r, chan_t g, chan_t b);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel %0d/%0d/%0d with none expected", r, g, b));
      end else begin
        want = pixel_q.pop_front();
        if (r !== want.r) report($sformatf("red got %0d want %0d", r, want.r));
        if (g !== want.g) report($sformatf("green got %0d want %0d", g, want.g));
        if (b !== want.b) report($sformatf("blue got %0d want %0d", b, want.b));
      end
    endtask
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  sample_t                          sample_value_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  chan_t                            red_o;
  chan_t                            green_o;
  chan_t                            blue_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [s2rgb_pkg::CfgIdxBits-1:0] cfg_index_i;
  logic [SampleBits-1:0]            cfg_data_i;

  pixel_scoreboard colors;
  sample_t         sample_q[$];
  int              src_idle_pct;
  int              sink_idle_pct;

  scalar_to_rgb_colormap u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_value_i,
    .out_valid_o,
    .out_ready_i,
    .red_o,
    .green_o,
    .blue_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) colors.check_pixel(red_o, green_o, blue_o);
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic stream_samples();
    while (sample_q.size() != 0) begin
      if ($urandom_range(99) < src_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        in_valid_i     <= 1'b1;
        sample_value_i <= sample_q[0];
        do @(posedge clk_i); while (!in_ready_o);
        colors.note_sample(sample_q.pop_front());
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (colors.pending() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 6) @(posedge clk_i);
  endtask

  task automatic write_config(logic hue_sel, sample_t lo, sample_t hi, sample_t ctr);
    logic [SampleBits-1:0] vals[4];
    s2rgb_pkg::cfg_reg_e   idx;
    vals[s2rgb_pkg::CfgMode]      = {(SampleBits - 1)'($urandom), hue_sel};
    vals[s2rgb_pkg::CfgLowLimit]  = lo;
    vals[s2rgb_pkg::CfgHighLimit] = hi;
    vals[s2rgb_pkg::CfgCenter]    = ctr;
    idx = s2rgb_pkg::CfgMode;
    repeat (4) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      colors.write_reg(idx, vals[idx]);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic sample_t pick_sample(longint lo, longint hi);
    longint      a, b, t;
    int unsigned sel;
    a   = (lo < hi) ? lo : hi;
    b   = (lo < hi) ? hi : lo;
    sel = $urandom_range(99);
    if (sel < 70) begin
      t = a + longint'($urandom_range(int'(b - a)));
    end else if (sel < 85) begin
      t = ((sel & 1) ? a : b) + longint'($urandom_range(8)) - 4;
      if (t < -32768) t = -32768;
      if (t > 32767) t = 32767;
    end else begin
      t = longint'(sample_t'($urandom));
    end
    return sample_t'(t);
  endfunction

  task automatic random_segment(int n_samples);
    sample_t     lo, hi, ctr, t;
    logic        hue_sel;
    int unsigned kind;
    hue_sel = 1'($urandom);
    lo      = sample_t'($urandom);
    hi      = sample_t'($urandom);
    kind    = $urandom_range(7);
    case (kind)
      0: begin
        lo = 16'sh8000;
        hi = 16'sh7FFF;
      end
      1: ;
      2: hi = (lo > 32767 - 256) ? 16'sh7FFF : lo + sample_t'($urandom_range(255));
      3: hi = lo;
      default: if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    endcase
    case ($urandom_range(3))
      0, 1: ctr = pick_sample(lo, hi);
      2: ctr = sample_t'($urandom);
      default: ctr = $urandom_range(1) ? hi : lo;
    endcase
    write_config(hue_sel, lo, hi, ctr);
    repeat (n_samples) sample_q.push_back(pick_sample(lo, hi));
    stream_samples();
    wait_drained();
  endtask

  task automatic run_list(sample_t list[$]);
    sample_q = list;
    stream_samples();
    wait_drained();
  endtask

  initial begin
    colors         = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = s2rgb_pkg::CfgMode;
    cfg_data_i     = '0;
    src_idle_pct   = 17;
    sink_idle_pct  = 83;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, jet
    run_list('{16'sh8000, 16'sh0000, 16'sh4000, 16'sh7FFF, 16'shFFFF});
    // full-range hue wheel, top of range wraps to red
    write_config(1'b1, 16'sh8000, 16'sh7FFF, 16'sh0000);
    run_list('{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh1555, 16'sh2AAB});
    // zero span and zero green span
    write_config(1'b0, 16'sd100, 16'sd100, 16'sd100);
    run_list('{16'sd100, -16'sd5, 16'sh7FFF});
    write_config(1'b1, 16'sd100, 16'sd100, 16'sd0);
    run_list('{16'sd0, 16'sd500});
    // inverted limits, center outside the range or at the high limit
    write_config(1'b0, 16'sd1000, -16'sd1000, 16'sd5000);
    run_list('{16'sd0, 16'sh8000});
    write_config(1'b1, 16'sd1000, -16'sd1000, 16'sd0);
    run_list('{16'sd0, 16'sh7FFF});
    write_config(1'b0, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    run_list('{16'sd0, 16'sh8000});
    write_config(1'b0, -16'sd100, 16'sd100, 16'sh8000);
    run_list('{16'sd50, -16'sd100});

    repeat (4) random_segment(42);
    src_idle_pct  = 83;
    sink_idle_pct = 17;
    repeat (4) random_segment(42);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (4) random_segment(42);

    wait_drained();
    if (colors.pending() != 0) colors.report("pixels still expected at end of run");
    if (colors.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
